/* rtl/sks_pkg.sv */
package sks_pkg;

  // field and bus widths
  localparam int CNT_W     = 6;
  localparam int WORD_W    = 32;
  localparam int KEY_W     = 64;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 136;

  localparam int SUBKEY_TOTAL_DEF = 33;

  // prekey recurrence constants
  localparam logic [WORD_W-1:0] PHI = 32'h9E3779B9;
  localparam int                ROT = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  // key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  // serpent s-boxes
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd3,  4'd8,  4'd15, 4'd1,  4'd10, 4'd6,  4'd5,  4'd11,
      4'd14, 4'd13, 4'd4,  4'd2,  4'd7,  4'd0,  4'd9,  4'd12},
    '{4'd15, 4'd12, 4'd2,  4'd7,  4'd9,  4'd0,  4'd5,  4'd10,
      4'd1,  4'd11, 4'd14, 4'd8,  4'd6,  4'd13, 4'd3,  4'd4},
    '{4'd8,  4'd6,  4'd7,  4'd9,  4'd3,  4'd12, 4'd10, 4'd15,
      4'd13, 4'd1,  4'd14, 4'd4,  4'd0,  4'd11, 4'd5,  4'd2},
    '{4'd0,  4'd15, 4'd11, 4'd8,  4'd12, 4'd9,  4'd6,  4'd3,
      4'd13, 4'd1,  4'd2,  4'd4,  4'd10, 4'd7,  4'd5,  4'd14},
    '{4'd1,  4'd15, 4'd8,  4'd3,  4'd12, 4'd0,  4'd11, 4'd6,
      4'd2,  4'd5,  4'd4,  4'd10, 4'd9,  4'd14, 4'd7,  4'd13},
    '{4'd15, 4'd5,  4'd2,  4'd11, 4'd4,  4'd10, 4'd9,  4'd12,
      4'd0,  4'd3,  4'd14, 4'd8,  4'd13, 4'd6,  4'd7,  4'd1},
    '{4'd7,  4'd2,  4'd12, 4'd5,  4'd8,  4'd4,  4'd6,  4'd11,
      4'd14, 4'd9,  4'd1,  4'd15, 4'd13, 4'd3,  4'd10, 4'd0},
    '{4'd1,  4'd13, 4'd15, 4'd0,  4'd14, 4'd8,  4'd2,  4'd11,
      4'd7,  4'd4,  4'd12, 4'd10, 4'd9,  4'd3,  4'd5,  4'd6}
  };

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             last;
    logic [CNT_W-1:0] index;
  } sks_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } sks_sts_t;

  function automatic logic [3:0] sbox_sub(input logic [2:0] box, input logic [3:0] nib);
    return SBOX[box][nib];
  endfunction

  function automatic logic [WORD_W-1:0] rol_prekey(input logic [WORD_W-1:0] v);
    return {v[WORD_W-ROT-1:0], v[WORD_W-1:WORD_W-ROT]};
  endfunction

endpackage

/* rtl/serpent_key_schedule.sv */
// a start request moves the controller to run, whose first step registers subkey 0
// throughput: one 128-bit subkey per cycle while out_tready is high, set by the
// four-word prekey step and one bitsliced s-box pass per cycle
// the next start request is taken the cycle after the last subkey is produced
// reset: synchronous, active low; key words clear, key length set to 256 bits, idle
module serpent_key_schedule
  import sks_pkg::*;
#(
  parameter int SUBKEY_TOTAL = SUBKEY_TOTAL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // [5:0] subkey_count, [7:6] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // [5:0] subkey_index, [69:6] subkey_high,
                                           // [133:70] subkey_low, [135:134] zero
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  sks_cmd_t cmd;
  sks_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  sks_ctrl #(
    .SUBKEY_TOTAL(SUBKEY_TOTAL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  sks_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/sks_ctrl.sv */
module sks_ctrl
  import sks_pkg::*;
#(
  parameter int SUBKEY_TOTAL = SUBKEY_TOTAL_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  output sks_cmd_t        cmd,
  input  sks_sts_t        sts
);

  localparam logic [CNT_W-1:0] TOTAL = CNT_W'(SUBKEY_TOTAL);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] kidx_r, kidx_nxt;
  logic [CNT_W-1:0] count_sat;

  // requested count, clipped to the subkey total
  assign count_sat = (in_tdata[CNT_W-1:0] > TOTAL) ? TOTAL : in_tdata[CNT_W-1:0];

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    kidx_nxt  = kidx_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.last  = 1'b0;
    cmd.index = kidx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          left_nxt = count_sat;
          kidx_nxt = '0;
          if (count_sat != '0) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          cmd.last = (left_r == CNT_W'(1));
          left_nxt = left_r - CNT_W'(1);
          kidx_nxt = kidx_r + CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
      kidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  // a subkey is only produced into a free output register
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> sts.out_free) else $error("step into occupied output");

  // running always has subkeys outstanding
  a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (left_r != '0)) else $error("run with nothing left");

  // last subkey returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> (state_r == ST_IDLE)) else $error("no return to idle after last");

  // a new request never lands during a run
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.step) else $error("load during step");

endmodule

/* rtl/sks_dp.sv */
module sks_dp
  import sks_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  sks_cmd_t             cmd,
  output sks_sts_t             sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast
);

  logic [KEY_W-1:0]  key_r [4];
  logic [1:0]        klen_r;
  logic [KEY_W-1:0]  kpad [4];

  logic [WORD_W-1:0] window_r [8];
  logic [IDX_W-1:0]  pidx_r;
  logic [WORD_W-1:0] ext [12];
  logic [2:0]        box;
  logic [3:0]        nib [WORD_W];
  logic [3:0]        sub [WORD_W];
  logic [WORD_W-1:0] y [4];

  logic              out_valid_r;
  logic [CNT_W-1:0]  out_idx_r;
  logic [KEY_W-1:0]  out_high_r;
  logic [KEY_W-1:0]  out_low_r;
  logic              out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0;
      key_r[1] <= '0;
      key_r[2] <= '0;
      key_r[3] <= '0;
      klen_r   <= KLEN_256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_WORD_0: key_r[0] <= cfg_data;
        REG_KEY_WORD_1: key_r[1] <= cfg_data;
        REG_KEY_WORD_2: key_r[2] <= cfg_data;
        REG_KEY_WORD_3: key_r[3] <= cfg_data;
        REG_KEY_LENGTH: klen_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // padded key: one set bit just above a short key
  always_comb begin
    kpad[0] = key_r[0];
    kpad[1] = key_r[1];
    kpad[2] = key_r[2];
    kpad[3] = key_r[3];
    if (klen_r == KLEN_128) begin
      kpad[2] = KEY_W'(1);
      kpad[3] = '0;
    end else if (klen_r == KLEN_192) begin
      kpad[3] = KEY_W'(1);
    end
  end

  // four prekey words per step
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      ext[j] = window_r[j];
    end
    for (int j = 0; j < 4; j++) begin
      ext[j+8] = rol_prekey(ext[j] ^ ext[j+3] ^ ext[j+5] ^ ext[j+7] ^ PHI ^
                            {{(WORD_W-IDX_W){1'b0}}, pidx_r + IDX_W'(j)});
    end
  end

  // bitsliced s-box, box (3 - k) mod 8
  assign box = 3'd3 - cmd.index[2:0];

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      nib[b] = {ext[11][b], ext[10][b], ext[9][b], ext[8][b]};
      sub[b] = sbox_sub(box, nib[b]);
      for (int n = 0; n < 4; n++) begin
        y[n][b] = sub[b][n];
      end
    end
  end

  // prekey window and index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < 4; j++) begin
        window_r[2*j]   <= kpad[j][WORD_W-1:0];
        window_r[2*j+1] <= kpad[j][KEY_W-1:WORD_W];
      end
      pidx_r <= '0;
    end else if (cmd.step) begin
      for (int j = 0; j < 8; j++) begin
        window_r[j] <= ext[j+4];
      end
      pidx_r <= pidx_r + IDX_W'(4);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_idx_r  <= cmd.index;
      out_high_r <= {y[3], y[2]};
      out_low_r  <= {y[1], y[0]};
      out_last_r <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tlast    = out_last_r;
  assign out_tdata    = {{(OUT_W-CNT_W-2*KEY_W){1'b0}}, out_low_r, out_high_r, out_idx_r};

  // a held result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_idx_r)) else $error("result overwritten");

  // load and step never coincide
  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step)) else $error("load and step together");

  // a step always leaves a valid result
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r) else $error("step lost");

endmodule
